@@ hw/rtl/masked_template_record_match_assert.svh @@
// assertion macros for the masked template record match block
// expects clk and rst_n in the scope of use
`ifndef MASKED_TEMPLATE_RECORD_MATCH_ASSERT_SVH
`define MASKED_TEMPLATE_RECORD_MATCH_ASSERT_SVH

// same-cycle implication
`define MTRM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtrm assertion failed");

// next-cycle implication
`define MTRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtrm assertion failed");

`endif

@@ hw/rtl/mtrm_pkg.sv @@
// shared types and constants for the masked template record match block
// no dependencies
`timescale 1ns / 1ps

package mtrm_pkg;

  localparam int CMD_W   = 2;
  localparam int SEL_W   = 64;
  localparam int OFF_W   = 12;
  localparam int BIT_W   = OFF_W + 1;
  localparam int IDX_W   = BIT_W - 3;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 16;

  localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIELD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPARE = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hffff;

  typedef struct packed {
    logic clr_step;
    logic load_begin;
    logic load_field;
    logic fld_rd;
    logic fld_wr;
    logic cmp_load;
    logic cmp_finish;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic fld_mark;
    logic fld_last;
    logic cmp_last;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/mtrm_ram.sv @@
// generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module mtrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/mtrm_ctrl.sv @@
// sequencer for the masked template record match block
// depends on mtrm_pkg
`timescale 1ns / 1ps

module mtrm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [mtrm_pkg::CMD_W-1:0] in_command,
  output logic                       in_stall,
  input  mtrm_pkg::stat_t            st,
  output mtrm_pkg::ctl_t             ctl
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FRD,
    S_FWR,
    S_CMP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            mtrm_pkg::CMD_BEGIN: begin
              ctl.load_begin = 1'b1;
              state_nxt      = S_CLEAR;
            end
            mtrm_pkg::CMD_FIELD: begin
              ctl.load_field = 1'b1;
              if (st.fld_mark) begin
                state_nxt = S_FRD;
              end
            end
            mtrm_pkg::CMD_COMPARE: begin
              ctl.cmp_load = 1'b1;
              state_nxt    = S_CMP;
            end
            default: begin
            end
          endcase
        end
      end
      S_FRD: begin
        ctl.fld_rd = 1'b1;
        state_nxt  = S_FWR;
      end
      S_FWR: begin
        ctl.fld_wr = 1'b1;
        state_nxt  = st.fld_last ? S_IDLE : S_FRD;
      end
      S_CMP: begin
        if (!st.cmp_last || st.out_free) begin
          ctl.cmp_finish = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/mtrm_dp.sv @@
// datapath: selection tracking, mask byte marking, record compare and result register
// depends on mtrm_pkg and mtrm_ram
`timescale 1ns / 1ps

module mtrm_dp #(
  parameter int MASK_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtrm_pkg::ctl_t                ctl,
  output mtrm_pkg::stat_t               st,
  input  logic [mtrm_pkg::SEL_W-1:0]    in_component_mask,
  input  logic [mtrm_pkg::OFF_W-1:0]    in_field_offset,
  input  logic [mtrm_pkg::OFF_W-1:0]    in_field_length,
  input  logic [mtrm_pkg::BYTE_W-1:0]   in_record_byte,
  input  logic [mtrm_pkg::BYTE_W-1:0]   in_template_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_matched,
  output logic [mtrm_pkg::CNT_W-1:0]    out_matched_count
);

  localparam int AW    = $clog2(MASK_BYTES);
  localparam int IDX_W = mtrm_pkg::IDX_W;
  localparam int BIT_W = mtrm_pkg::BIT_W;
  localparam int BW    = mtrm_pkg::BYTE_W;
  localparam logic [IDX_W:0] IDX_LIM = (IDX_W + 1)'(MASK_BYTES);
  localparam logic [AW:0]    POS_LIM = (AW + 1)'(MASK_BYTES);
  localparam logic [AW-1:0]  CLR_END = AW'(MASK_BYTES - 1);

  logic [mtrm_pkg::SEL_W-1:0] sel_r, sel_nxt;
  logic                       ended_r, ended_nxt;
  logic [AW:0]                pos_r, pos_nxt;
  logic                       mis_r, mis_nxt;
  logic [mtrm_pkg::CNT_W-1:0] total_r, total_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [IDX_W-1:0]           last_idx_r, last_idx_nxt;
  logic                       first_r, first_nxt;
  logic [2:0]                 lo_r, lo_nxt;
  logic [2:0]                 hi_r, hi_nxt;
  logic [BW-1:0]              rec_r, rec_nxt;
  logic [BW-1:0]              tpl_r, tpl_nxt;
  logic                       last_r, last_nxt;
  logic                       inrng_r, inrng_nxt;
  logic                       oval_r, oval_nxt;
  logic                       omatch_r, omatch_nxt;
  logic [mtrm_pkg::CNT_W-1:0] ocount_r, ocount_nxt;

  logic [BIT_W-1:0] end_bit;
  logic [BIT_W-1:0] last_bit;
  logic [2:0]       cur_lo;
  logic [2:0]       cur_hi;
  logic [BW-1:0]    byte_mask;
  logic [BW-1:0]    cmp_mask;
  logic             mis_cur;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [BW-1:0]    ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [BW-1:0]    ram_rdata;

  assign end_bit  = {1'b0, in_field_offset} + {1'b0, in_field_length};
  assign last_bit = end_bit - BIT_W'(1);

  // per-byte bit range, msb-first
  assign cur_lo    = first_r ? lo_r : 3'd0;
  assign cur_hi    = (idx_r == last_idx_r) ? hi_r : 3'd7;
  assign byte_mask = (mtrm_pkg::BYTE_ONES >> cur_lo) & (mtrm_pkg::BYTE_ONES << (3'd7 - cur_hi));

  assign cmp_mask = inrng_r ? ram_rdata : '0;
  assign mis_cur  = mis_r | (|((rec_r ^ tpl_r) & cmp_mask));

  assign st.clr_last = (clr_addr_r == CLR_END);
  assign st.fld_mark = !ended_r && (sel_r != '0) && (in_field_length != '0) && sel_r[0]
                       && ({2'b00, in_field_offset[mtrm_pkg::OFF_W-1:3]} < IDX_LIM);
  assign st.fld_last = (idx_r == last_idx_r) || (({1'b0, idx_r} + (IDX_W + 1)'(1)) >= IDX_LIM);
  assign st.cmp_last = last_r;
  assign st.out_free = !oval_r || !out_stall;

  always_comb begin
    sel_nxt      = sel_r;
    ended_nxt    = ended_r;
    pos_nxt      = pos_r;
    mis_nxt      = mis_r;
    total_nxt    = total_r;
    clr_addr_nxt = clr_addr_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    first_nxt    = first_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    rec_nxt      = rec_r;
    tpl_nxt      = tpl_r;
    last_nxt     = last_r;
    inrng_nxt    = inrng_r;
    oval_nxt     = oval_r && out_stall;
    omatch_nxt   = omatch_r;
    ocount_nxt   = ocount_r;

    if (ctl.clr_step) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
    end

    if (ctl.load_begin) begin
      sel_nxt      = in_component_mask;
      ended_nxt    = (in_component_mask == '0);
      pos_nxt      = '0;
      mis_nxt      = 1'b0;
      total_nxt    = '0;
      clr_addr_nxt = '0;
    end

    if (ctl.load_field && !ended_r) begin
      if (sel_r == '0 || in_field_length == '0) begin
        ended_nxt = 1'b1;
      end else begin
        sel_nxt   = sel_r >> 1;
        ended_nxt = ((sel_r >> 1) == '0);
      end
      idx_nxt      = {1'b0, in_field_offset[mtrm_pkg::OFF_W-1:3]};
      last_idx_nxt = last_bit[BIT_W-1:3];
      first_nxt    = 1'b1;
      lo_nxt       = in_field_offset[2:0];
      hi_nxt       = last_bit[2:0];
    end

    if (ctl.fld_wr) begin
      idx_nxt   = idx_r + IDX_W'(1);
      first_nxt = 1'b0;
    end

    if (ctl.cmp_load) begin
      rec_nxt   = in_record_byte;
      tpl_nxt   = in_template_byte;
      last_nxt  = in_last_byte;
      inrng_nxt = (pos_r < POS_LIM);
      if (pos_r < POS_LIM) begin
        pos_nxt = pos_r + (AW + 1)'(1);
      end
    end

    if (ctl.cmp_finish) begin
      if (last_r) begin
        if (!mis_cur && total_r != mtrm_pkg::CNT_MAX) begin
          total_nxt  = total_r + mtrm_pkg::CNT_W'(1);
          ocount_nxt = total_r + mtrm_pkg::CNT_W'(1);
        end else begin
          ocount_nxt = total_r;
        end
        omatch_nxt = !mis_cur;
        oval_nxt   = 1'b1;
        pos_nxt    = '0;
        mis_nxt    = 1'b0;
      end else begin
        mis_nxt = mis_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r      <= '0;
      ended_r    <= 1'b1;
      pos_r      <= '0;
      mis_r      <= 1'b0;
      total_r    <= '0;
      clr_addr_r <= '0;
      oval_r     <= 1'b0;
    end else begin
      sel_r      <= sel_nxt;
      ended_r    <= ended_nxt;
      pos_r      <= pos_nxt;
      mis_r      <= mis_nxt;
      total_r    <= total_nxt;
      clr_addr_r <= clr_addr_nxt;
      oval_r     <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    first_r    <= first_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    rec_r      <= rec_nxt;
    tpl_r      <= tpl_nxt;
    last_r     <= last_nxt;
    inrng_r    <= inrng_nxt;
    omatch_r   <= omatch_nxt;
    ocount_r   <= ocount_nxt;
  end

  // mask store: clearing sweep and read-modify-write of field bytes
  assign ram_we    = ctl.clr_step | ctl.fld_wr;
  assign ram_waddr = ctl.clr_step ? clr_addr_r : idx_r[AW-1:0];
  assign ram_wdata = ctl.clr_step ? '0 : (ram_rdata | byte_mask);
  assign ram_re    = ctl.fld_rd | ctl.cmp_load;
  assign ram_raddr = ctl.fld_rd ? idx_r[AW-1:0] : pos_r[AW-1:0];

  mtrm_ram #(
    .WIDTH (BW),
    .DEPTH (MASK_BYTES)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid         = oval_r;
  assign out_matched       = omatch_r;
  assign out_matched_count = ocount_r;

endmodule

@@ hw/rtl/masked_template_record_match.sv @@
// masked template record match top level; depends on mtrm_pkg, mtrm_ctrl, mtrm_dp
// compare byte: each transfer is followed by a compare state; on the last byte it waits for a free result register
// descriptor: a read state and a write state per marked mask byte (read-modify-write of one ram port)
// begin: starts a clearing sweep over all MASK_BYTES words of the mask ram
// reset: the same clearing sweep, in_stall held high until done
`timescale 1ns / 1ps

`include "masked_template_record_match_assert.svh"

module masked_template_record_match #(
  parameter int MASK_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mtrm_pkg::CMD_W-1:0]    in_command,
  input  logic [mtrm_pkg::SEL_W-1:0]    in_component_mask,
  input  logic [mtrm_pkg::OFF_W-1:0]    in_field_offset,
  input  logic [mtrm_pkg::OFF_W-1:0]    in_field_length,
  input  logic [mtrm_pkg::BYTE_W-1:0]   in_record_byte,
  input  logic [mtrm_pkg::BYTE_W-1:0]   in_template_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_matched,
  output logic [mtrm_pkg::CNT_W-1:0]    out_matched_count
);

  mtrm_pkg::ctl_t  ctl;
  mtrm_pkg::stat_t st;
  logic            in_xfer;

  assign in_xfer = in_valid && !in_stall;

  mtrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .st         (st),
    .ctl        (ctl)
  );

  mtrm_dp #(
    .MASK_BYTES (MASK_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .st                (st),
    .in_component_mask (in_component_mask),
    .in_field_offset   (in_field_offset),
    .in_field_length   (in_field_length),
    .in_record_byte    (in_record_byte),
    .in_template_byte  (in_template_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched       (out_matched),
    .out_matched_count (out_matched_count)
  );

  `MTRM_ASSERT_NEXT(a_begin_sweeps, in_xfer && in_command == mtrm_pkg::CMD_BEGIN, in_stall)
  `MTRM_ASSERT_NEXT(a_compare_busy, in_xfer && in_command == mtrm_pkg::CMD_COMPARE, in_stall)
  `MTRM_ASSERT_IMPL(a_match_counted, out_valid && out_matched, out_matched_count != '0)

endmodule

@@ sim/mtrm_match_checker.sv @@
// checker for the masked template record match block: watches both channels,
// predicts each result and compares it field by field; depends on mtrm_pkg
`timescale 1ns / 1ps

module mtrm_match_checker #(
  parameter int MASK_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mtrm_pkg::CMD_W-1:0]    in_command,
  input  logic [mtrm_pkg::SEL_W-1:0]    in_component_mask,
  input  logic [mtrm_pkg::OFF_W-1:0]    in_field_offset,
  input  logic [mtrm_pkg::OFF_W-1:0]    in_field_length,
  input  logic [mtrm_pkg::BYTE_W-1:0]   in_record_byte,
  input  logic [mtrm_pkg::BYTE_W-1:0]   in_template_byte,
  input  logic                          in_last_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_matched,
  input  logic [mtrm_pkg::CNT_W-1:0]    out_matched_count,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen,
  output int                            matched_seen
);
  import mtrm_pkg::*;

  typedef struct packed {
    logic             matched;
    logic [CNT_W-1:0] count;
  } match_result_t;

  logic [BYTE_W-1:0] mask_bytes [MASK_BYTES];
  logic [SEL_W-1:0]  sel_left;
  logic              list_done;
  int                rec_pos;
  logic              diff_seen;
  logic [CNT_W-1:0]  match_tally;
  match_result_t     pending_matches [$];

  task automatic wipe_mask_and_tally();
    for (int i = 0; i < MASK_BYTES; i++) mask_bytes[i] = '0;
    rec_pos     = 0;
    diff_seen   = 1'b0;
    match_tally = '0;
  endtask

  task automatic update_mask_and_match(
    input logic [CMD_W-1:0]  cmd,
    input logic [SEL_W-1:0]  sel,
    input logic [OFF_W-1:0]  off,
    input logic [OFF_W-1:0]  len,
    input logic [BYTE_W-1:0] rec,
    input logic [BYTE_W-1:0] tpl,
    input logic              last
  );
    int            bit_at;
    int            bit_end;
    logic [BYTE_W-1:0] m;
    match_result_t due;
    case (cmd)
      CMD_BEGIN: begin
        wipe_mask_and_tally();
        sel_left  = sel;
        list_done = (sel == '0);
      end
      CMD_FIELD: begin
        if (!list_done) begin
          if (sel_left == '0 || len == '0) begin
            list_done = 1'b1;
          end else begin
            if (sel_left[0]) begin
              bit_end = int'(off) + int'(len);
              for (bit_at = int'(off); bit_at < bit_end; bit_at++) begin
                if ((bit_at >> 3) < MASK_BYTES)
                  mask_bytes[bit_at >> 3] |= BYTE_W'(8'h80 >> (bit_at & 7));
              end
            end
            sel_left = sel_left >> 1;
            if (sel_left == '0) list_done = 1'b1;
          end
        end
      end
      CMD_COMPARE: begin
        m = '0;
        // bytes past the mask compare under a zero mask
        if (rec_pos < MASK_BYTES) begin
          m = mask_bytes[rec_pos];
          rec_pos++;
        end
        if (((rec ^ tpl) & m) != '0) diff_seen = 1'b1;
        if (last) begin
          due.matched = !diff_seen;
          if (!diff_seen && match_tally != CNT_MAX) match_tally++;
          due.count = match_tally;
          pending_matches.push_back(due);
          rec_pos   = 0;
          diff_seen = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    match_result_t want;
    if (!rst_n) begin
      wipe_mask_and_tally();
      sel_left  = '0;
      list_done = 1'b1;
      pending_matches.delete();
      fail_count   = 0;
      results_seen = 0;
      matched_seen = 0;
    end else begin
      // result side first, so a transfer in this cycle cannot satisfy itself
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_matched === 1'b1) matched_seen++;
        if (pending_matches.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result transfer with none expected: matched %b count %0d",
                     $realtime, out_matched, out_matched_count);
        end else begin
          want = pending_matches.pop_front();
          if (out_matched !== want.matched || out_matched_count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result differs: matched exp %b got %b, count exp %0d got %0d",
                       $realtime, want.matched, out_matched, want.count,
                       out_matched_count);
          end
        end
      end
      if (in_valid && !in_stall)
        update_mask_and_match(in_command, in_component_mask, in_field_offset,
                              in_field_length, in_record_byte, in_template_byte,
                              in_last_byte);
    end
    pending = pending_matches.size();
  end

endmodule

@@ sim/testbench.sv @@
// top of the masked template record match testbench: clock, reset, stimulus and verdict
// depends on mtrm_pkg, masked_template_record_match and mtrm_match_checker
`timescale 1ns / 1ps

module testbench;
  import mtrm_pkg::*;

  localparam int MASK_BYTES   = 256;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 520;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command;
  logic [SEL_W-1:0]  in_component_mask;
  logic [OFF_W-1:0]  in_field_offset;
  logic [OFF_W-1:0]  in_field_length;
  logic [BYTE_W-1:0] in_record_byte;
  logic [BYTE_W-1:0] in_template_byte;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_stall;
  logic              out_matched;
  logic [CNT_W-1:0]  out_matched_count;

  int fail_count;
  int pending;
  int results_seen;
  int matched_seen;
  int items_sent;
  bit dense;
  bit hold_req;

  masked_template_record_match #(
    .MASK_BYTES(MASK_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_component_mask(in_component_mask),
    .in_field_offset  (in_field_offset),
    .in_field_length  (in_field_length),
    .in_record_byte   (in_record_byte),
    .in_template_byte (in_template_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_matched      (out_matched),
    .out_matched_count(out_matched_count)
  );

  mtrm_match_checker #(
    .MASK_BYTES(MASK_BYTES)
  ) match_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_component_mask(in_component_mask),
    .in_field_offset  (in_field_offset),
    .in_field_length  (in_field_length),
    .in_record_byte   (in_record_byte),
    .in_template_byte (in_template_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_matched      (out_matched),
    .out_matched_count(out_matched_count),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen),
    .matched_seen     (matched_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (dense || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transfer on the input channel, driven at the falling edge
  task automatic send_item(
    input logic [CMD_W-1:0]  cmd,
    input logic [SEL_W-1:0]  sel,
    input logic [OFF_W-1:0]  off,
    input logic [OFF_W-1:0]  len,
    input logic [BYTE_W-1:0] rec,
    input logic [BYTE_W-1:0] tpl,
    input logic              last
  );
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_command        = cmd;
    in_component_mask = sel;
    in_field_offset   = off;
    in_field_length   = len;
    in_record_byte    = rec;
    in_template_byte  = tpl;
    in_last_byte      = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_begin(input logic [SEL_W-1:0] sel);
    send_item(CMD_BEGIN, sel, OFF_W'($urandom), OFF_W'($urandom), BYTE_W'($urandom),
              BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_field(input logic [OFF_W-1:0] off, input logic [OFF_W-1:0] len);
    send_item(CMD_FIELD, {$urandom, $urandom}, off, len, BYTE_W'($urandom),
              BYTE_W'($urandom), 1'($urandom));
  endtask

  // style 0 copies the record, 1 takes a random template, 2 flips one bit somewhere
  task automatic send_record(input int nbytes, input int style);
    logic [BYTE_W-1:0] rec;
    logic [BYTE_W-1:0] tpl;
    int flip_at;
    flip_at = $urandom_range(0, nbytes - 1);
    for (int i = 0; i < nbytes; i++) begin
      rec = BYTE_W'($urandom);
      case (style)
        0:       tpl = rec;
        1:       tpl = BYTE_W'($urandom);
        default: tpl = (i == flip_at) ? rec ^ (8'h01 << $urandom_range(0, 7)) : rec;
      endcase
      send_item(CMD_COMPARE, {$urandom, $urandom}, OFF_W'($urandom), OFF_W'($urandom),
                rec, tpl, i == nbytes - 1);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result side: random stall runs, plus one long hold-off on request
  initial begin
    int run;
    int r;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
        run = 0;
      end else begin
        if (run == 0) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            out_stall = 1'b0;
            run = $urandom_range(1, 8);
          end else if (r < 85) begin
            out_stall = 1'b1;
            run = $urandom_range(1, 3);
          end else if (r < 95) begin
            out_stall = 1'b0;
            run = $urandom_range(20, 60);
          end else begin
            out_stall = 1'b1;
            run = $urandom_range(20, 60);
          end
        end
        run--;
      end
    end
  end

  initial begin
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] rec;
    logic [BYTE_W-1:0] tpl;
    int base;
    int seq;
    int r;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = CMD_BEGIN;
    in_component_mask = '0;
    in_field_offset   = '0;
    in_field_length   = '0;
    in_record_byte    = '0;
    in_template_byte  = '0;
    in_last_byte      = 1'b0;
    dense             = 1'b0;
    hold_req          = 1'b0;
    items_sent        = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: unused command, compare straight after reset, zero selection
    send_item(CMD_UNUSED, '1, '1, '1, '1, '1, 1'b1);
    send_record(1, 1);
    send_begin('0);
    send_field(12'd0, 12'd8);
    send_record(2, 1);

    // full selection, fields at and past the mask end, list end on zero length
    send_begin('1);
    send_field(12'd0, 12'd4095);
    send_field(12'd4095, 12'd4095);
    send_field(12'd2047, 12'd1);
    send_field(12'd2048, 12'd1);
    send_field(12'd5, 12'd0);
    send_field(12'd0, 12'd8);
    send_record(2, 0);
    send_record(3, 1);

    // sparse selection runs out; record longer than the mask
    send_begin(64'h5);
    send_field(12'd0, 12'd8);
    send_field(12'd8, 12'd8);
    send_field(12'd16, 12'd4);
    send_field(12'd0, 12'd24);
    for (int i = 0; i < MASK_BYTES + 2; i++) begin
      rec = BYTE_W'($urandom);
      case (i)
        0:       tpl = rec;
        1:       tpl = rec ^ 8'hff;
        2:       tpl = rec ^ 8'h0f;
        default: tpl = BYTE_W'($urandom);
      endcase
      send_item(CMD_COMPARE, {$urandom, $urandom}, OFF_W'($urandom), OFF_W'($urandom),
                rec, tpl, i == MASK_BYTES + 1);
    end

    // random mask builds followed by records, with some noise
    drain_results();
    base = items_sent;
    seq  = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      dense = ($urandom_range(0, 3) == 0);
      if (seq % 7 == 3) drain_results();
      if (seq == 4) begin
        hold_req = 1'b1;
        repeat (40) send_record(1, 0);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          send_item(CMD_W'($urandom_range(0, 3)), {$urandom, $urandom}, OFF_W'($urandom),
                    OFF_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                    1'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30)      sel = {$urandom, $urandom};
        else if (r < 80) sel = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 8)) - 1);
        else if (r < 88) sel = '0;
        else if (r < 93) sel = '1;
        else             sel = 64'd1 << $urandom_range(0, 63);
        send_begin(sel);
        repeat ($urandom_range(0, 10)) begin
          r = $urandom_range(0, 99);
          if (r < 8)       send_field(OFF_W'($urandom), 12'd0);
          else if (r < 13) send_field(OFF_W'($urandom), OFF_W'($urandom));
          else             send_field(OFF_W'($urandom_range(0, 319)),
                                      OFF_W'($urandom_range(1, 48)));
        end
        repeat ($urandom_range(1, 5)) begin
          r = $urandom_range(0, 99);
          if (r < 3)       send_record($urandom_range(MASK_BYTES + 1, MASK_BYTES + 44),
                                       $urandom_range(0, 2));
          else if (r < 60) send_record($urandom_range(1, 8), $urandom_range(0, 2));
          else             send_record($urandom_range(1, 40), $urandom_range(0, 2));
        end
      end
      seq++;
    end
    dense = 1'b0;

    send_record(1, 0);
    drain_results();
    repeat (64) @(negedge clk);
    $display("%0d transfers in, %0d results checked (%0d matches)",
             items_sent, results_seen, matched_seen);
    $display("covered empty and full masks, fields past the mask, overlong records"
             , " and a long result hold-off with the input backed up");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
